/* design/ctc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ctc_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 8;
	localparam int COUNT_WIDTH = 32;

	localparam int PATTERN_W = 64;
	localparam int SPAN_W    = 4;
	localparam int CELLS_W   = 7;
	localparam int INDEX_W   = 10;
	localparam int OUT_CNT_W = 32;
	localparam int TOTAL_W   = 32;
	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int USED_W    = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		OUT_MATCH,
		OUT_INSERT,
		OUT_FULL
	} ctc_outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_MISS
	} ctc_state_t;

	typedef struct packed {
		logic [PATTERN_W-1:0]   bitmap;
		logic [SPAN_W-1:0]      rows;
		logic [SPAN_W-1:0]      cols;
		logic [COUNT_WIDTH-1:0] count;
	} ctc_entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit_hit;
		logic commit_miss;
	} ctc_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_end;
		logic out_busy;
	} ctc_sts_t;

endpackage
`default_nettype wire

/* design/ctc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctc_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* design/ctc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctc_ctrl
	import ctc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire ctc_sts_t sts,
	output ctc_cmd_t      cmd
);

	ctc_state_t state_q;
	ctc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// A match on the word read last cycle ends the search at once.
				priority if (sts.hit) begin
					cmd.scan = 1'b1;
					state_d  = ST_HIT;
				end else if (sts.scan_end) begin
					state_d = ST_MISS;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_HIT: begin
				if (!sts.out_busy) begin
					cmd.commit_hit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (!sts.out_busy) begin
					cmd.commit_miss = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* design/ctc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctc_datapath
	import ctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctc_cmd_t             cmd,
	output ctc_sts_t                  sts,
	input  wire logic [PATTERN_W-1:0] pattern_bits,
	input  wire logic [SPAN_W-1:0]    row_span,
	input  wire logic [SPAN_W-1:0]    col_span,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [INDEX_W-1:0]        entry_index,
	output logic [1:0]                outcome,
	output logic [OUT_CNT_W-1:0]      entry_count,
	output logic [TOTAL_W-1:0]        total_clusters
);

	logic [SPAN_W-1:0]    rows_c;
	logic [SPAN_W-1:0]    cols_c;
	logic [CELLS_W-1:0]   cells_c;
	logic [PATTERN_W-1:0] mask_c;

	logic [PATTERN_W-1:0]   bits_q;
	logic [SPAN_W-1:0]      rows_q;
	logic [SPAN_W-1:0]      cols_q;
	logic [USED_W-1:0]      rd_idx_q;
	logic                   cmp_valid_s1;
	logic [USED_W-1:0]      cmp_idx_s1;
	logic [USED_W-1:0]      used_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [USED_W-1:0]      hit_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;

	logic                   rd_en;
	ctc_entry_t             rd_entry;
	logic [$bits(ctc_entry_t)-1:0] rd_word;
	logic                   wr_en;
	logic [USED_W-1:0]      wr_idx;
	ctc_entry_t             wr_entry;
	logic                   match;
	logic [COUNT_WIDTH-1:0] next_cnt;

	logic                   out_valid_q;
	logic [INDEX_W-1:0]     index_q;
	ctc_outcome_t           outcome_q;
	logic [OUT_CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0]     total_res_q;

	// Spans above the maximum saturate; the bitmap is cut to the rectangle.
	always_comb begin
		rows_c  = (row_span > SPAN_W'(MAX_ROWS)) ? SPAN_W'(MAX_ROWS) : row_span;
		cols_c  = (col_span > SPAN_W'(MAX_COLS)) ? SPAN_W'(MAX_COLS) : col_span;
		cells_c = CELLS_W'(rows_c) * CELLS_W'(cols_c);
		for (int b = 0; b < PATTERN_W; b++) begin
			mask_c[b] = (CELLS_W'(b) < cells_c);
		end
	end

	assign rd_en    = cmd.scan && (rd_idx_q < used_q);
	assign rd_entry = ctc_entry_t'(rd_word);
	assign match    = (rd_entry.bitmap == bits_q) && (rd_entry.rows == rows_q) &&
		(rd_entry.cols == cols_q);

	assign sts.hit      = cmp_valid_s1 && match;
	assign sts.scan_end = !cmp_valid_s1 && (rd_idx_q == used_q);
	assign sts.out_busy = out_valid_q && out_stall;

	assign next_cnt = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;

	always_comb begin
		wr_entry.bitmap = bits_q;
		wr_entry.rows   = rows_q;
		wr_entry.cols   = cols_q;
		if (cmd.commit_hit) begin
			wr_en          = 1'b1;
			wr_idx         = hit_idx_q;
			wr_entry.count = next_cnt;
		end else begin
			wr_en          = cmd.commit_miss && (used_q < USED_W'(TABLE_DEPTH));
			wr_idx         = used_q;
			wr_entry.count = COUNT_WIDTH'(1);
		end
	end

	ctc_ram #(
		.WIDTH ($bits(ctc_entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[IDX_W-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits_q <= pattern_bits & mask_c;
			rows_q <= rows_c;
			cols_q <= cols_c;
		end
		if (cmd.scan) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (cmd.scan && sts.hit) begin
			hit_idx_q <= cmp_idx_s1;
			hit_cnt_q <= rd_entry.count;
		end
		if (cmd.commit_hit) begin
			index_q   <= INDEX_W'(hit_idx_q);
			outcome_q <= OUT_MATCH;
			count_q   <= OUT_CNT_W'(next_cnt);
		end else if (cmd.commit_miss) begin
			if (used_q < USED_W'(TABLE_DEPTH)) begin
				index_q   <= INDEX_W'(used_q);
				outcome_q <= OUT_INSERT;
				count_q   <= OUT_CNT_W'(1);
			end else begin
				index_q   <= '0;
				outcome_q <= OUT_FULL;
				count_q   <= '0;
			end
		end
		// The running total moves on with the next word, so the result keeps its own copy.
		if (cmd.commit_hit || cmd.commit_miss) begin
			total_res_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			used_q       <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q     <= '0;
				cmp_valid_s1 <= 1'b0;
				if (total_q != '1) begin
					total_q <= total_q + 1'b1;
				end
			end else if (cmd.scan) begin
				cmp_valid_s1 <= rd_en && !sts.hit;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (cmd.commit_miss && (used_q < USED_W'(TABLE_DEPTH))) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.commit_hit || cmd.commit_miss) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign entry_index    = index_q;
	assign outcome        = outcome_q;
	assign entry_count    = count_q;
	assign total_clusters = total_res_q;

endmodule
`default_nettype wire

/* design/cluster_topology_counter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cluster topology counter: each input word is one pixel cluster (a row-major
// fired-pixel bitmap plus its row and column spans), and the block keeps a
// dictionary of the distinct topologies seen, with a saturating count for
// each. Spans above eight are taken as eight and bitmap bits outside the
// rectangle are cleared. An incoming cluster is compared against the stored
// entries in slot order, one entry per clock through the single read port of
// the table memory; a hit bumps that entry's count, a miss appends a new entry
// with count one, and when the table is full the cluster is reported as
// dropped. A result is registered once the linear scan of the table memory
// has met a match or the last used entry, and the next word can be taken in
// the cycle after the result is committed; items are processed one at a time.
// A result still stalled in the output register holds the sequencer before it
// commits the next one. A finished result waits in that output register, so
// the next word is taken while the previous result is still stalled. No
// clearing pass is needed after reset.
module cluster_topology_counter_core
	import ctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PATTERN_W-1:0] pattern_bits,
	input  wire logic [SPAN_W-1:0]    row_span,
	input  wire logic [SPAN_W-1:0]    col_span,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [INDEX_W-1:0]        entry_index,
	output logic [1:0]                outcome,
	output logic [OUT_CNT_W-1:0]      entry_count,
	output logic [TOTAL_W-1:0]        total_clusters
);

	// Commands from the sequencer and status back from the datapath.
	ctc_cmd_t cmd;
	ctc_sts_t sts;

	// The sequencer takes a word in idle, scans, then commits once the
	// output register is free.
	ctc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the key, the scan counter, the table memory, the
	// used-entry and cluster counters, and the output register.
	ctc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pattern_bits   (pattern_bits),
		.row_span       (row_span),
		.col_span       (col_span),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entry_index    (entry_index),
		.outcome        (outcome),
		.entry_count    (entry_count),
		.total_clusters (total_clusters)
	);

endmodule
`default_nettype wire

/* design/ctc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctc_checker
	import ctc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [INDEX_W-1:0]   entry_index,
	input wire logic [1:0]           outcome,
	input wire logic [OUT_CNT_W-1:0] entry_count,
	input wire logic [TOTAL_W-1:0]   total_clusters
);

	// Words are handled one at a time, so a taken word closes the input.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a word was taken");

	// A dropped cluster reports slot zero and count zero.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_FULL) |-> (entry_index == '0) && (entry_count == '0))
		else $error("dropped cluster with nonzero slot or count");

	// A freshly inserted entry always has count one.
	a_insert_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_INSERT) |-> (entry_count == OUT_CNT_W'(1)))
		else $error("inserted entry without count one");

	// Every result accounts at least the cluster that caused it.
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_clusters != '0))
		else $error("result with zero cluster total");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_index) &&
		$stable(outcome) && $stable(entry_count) && $stable(total_clusters))
		else $error("stalled result changed");

endmodule

bind cluster_topology_counter_core ctc_checker u_ctc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.entry_index    (entry_index),
	.outcome        (outcome),
	.entry_count    (entry_count),
	.total_clusters (total_clusters)
);
`default_nettype wire

/* tb/sv/cluster_topology_counter_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the cluster topology counter. Each input word is one
// cluster (bitmap plus row and column spans); the bench keeps its own copy of
// the topology dictionary, works out the result that every accepted word must
// produce, and compares the block's results against those in order.
module cluster_topology_counter_core_test;
	import ctc_pkg::*;

	// One input word as the sender offers it.
	typedef struct packed {
		logic [PATTERN_W-1:0] bits;
		logic [SPAN_W-1:0]    rows;
		logic [SPAN_W-1:0]    cols;
	} cluster_word_t;

	// One result word as the dictionary must report it.
	typedef struct packed {
		logic [INDEX_W-1:0]   index;
		ctc_outcome_t         kind;
		logic [OUT_CNT_W-1:0] count;
		logic [TOTAL_W-1:0]   total;
	} dict_result_t;

	localparam int RANDOM_WORDS   = 580;
	localparam int HOLD_AT_RESULT = 60;
	localparam int HOLD_CYCLES    = 300;
	// The slowest item scans the whole table, so the quiet tail after the last
	// result covers one full scan with some margin.
	localparam int TAIL_CYCLES    = TABLE_DEPTH + 100;
	localparam int PRINT_CAP      = 100;
	// Failsafe only: several times the slowest run.
	localparam int RUN_LIMIT_NS   = 40_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PATTERN_W-1:0] pattern_bits = '0;
	logic [SPAN_W-1:0]    row_span = SPAN_W'(1);
	logic [SPAN_W-1:0]    col_span = SPAN_W'(1);
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [INDEX_W-1:0]   entry_index;
	logic [1:0]           outcome;
	logic [OUT_CNT_W-1:0] entry_count;
	logic [TOTAL_W-1:0]   total_clusters;

	cluster_topology_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pattern_bits(pattern_bits),
		.row_span(row_span),
		.col_span(col_span),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry_index(entry_index),
		.outcome(outcome),
		.entry_count(entry_count),
		.total_clusters(total_clusters)
	);

	always #2 clk = ~clk;

	// Shadow dictionary. Only slots below dict_used are ever read, which is
	// also all the block guarantees for its own memory.
	logic [PATTERN_W-1:0]   dict_bits  [TABLE_DEPTH];
	logic [SPAN_W-1:0]      dict_rows  [TABLE_DEPTH];
	logic [SPAN_W-1:0]      dict_cols  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] dict_count [TABLE_DEPTH];
	int                     dict_used = 0;
	logic [TOTAL_W-1:0]     seen_total = '0;

	cluster_word_t pending_words[$];   // words not yet offered
	dict_result_t  tally_due[$];       // results still owed by the block
	cluster_word_t shape_pool[$];      // earlier clusters, reused to force hits

	int   words_queued = 0;
	int   words_taken = 0;
	int   results_seen = 0;
	int   mismatches = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;

	// Spans above the maximum are treated as the maximum; zero stays zero.
	function automatic logic [SPAN_W-1:0] clamp_span(logic [SPAN_W-1:0] s, int lim);
		return (s > lim) ? SPAN_W'(lim) : s;
	endfunction

	// Bitmap bits that lie inside the (clamped) bounding rectangle.
	function automatic logic [PATTERN_W-1:0] live_cells(logic [SPAN_W-1:0] r,
			logic [SPAN_W-1:0] c);
		int cells;
		cells = int'(clamp_span(r, MAX_ROWS)) * int'(clamp_span(c, MAX_COLS));
		if (cells >= PATTERN_W)
			return '1;
		return (PATTERN_W'(1) << cells) - PATTERN_W'(1);
	endfunction

	// Accounts one cluster in the shadow dictionary and returns the result the
	// block has to produce for it.
	function automatic dict_result_t tally_cluster(cluster_word_t w);
		logic [SPAN_W-1:0]    r;
		logic [SPAN_W-1:0]    c;
		logic [PATTERN_W-1:0] key;
		int                   slot;
		dict_result_t         res;
		r = clamp_span(w.rows, MAX_ROWS);
		c = clamp_span(w.cols, MAX_COLS);
		key = w.bits & live_cells(w.rows, w.cols);
		if (seen_total != '1)
			seen_total = seen_total + 1'b1;
		slot = -1;
		for (int i = 0; i < dict_used && slot < 0; i++)
			if (dict_rows[i] == r && dict_cols[i] == c && dict_bits[i] == key)
				slot = i;
		if (slot >= 0) begin
			if (dict_count[slot] != '1)
				dict_count[slot] = dict_count[slot] + 1'b1;
			res.index = INDEX_W'(slot);
			res.kind = OUT_MATCH;
			res.count = OUT_CNT_W'(dict_count[slot]);
		end else if (dict_used < TABLE_DEPTH) begin
			dict_bits[dict_used] = key;
			dict_rows[dict_used] = r;
			dict_cols[dict_used] = c;
			dict_count[dict_used] = COUNT_WIDTH'(1);
			res.index = INDEX_W'(dict_used);
			res.kind = OUT_INSERT;
			res.count = OUT_CNT_W'(1);
			dict_used++;
		end else begin
			res.index = '0;
			res.kind = OUT_FULL;
			res.count = '0;
		end
		res.total = seen_total;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic queue_cluster(logic [PATTERN_W-1:0] bits, logic [SPAN_W-1:0] rows,
			logic [SPAN_W-1:0] cols);
		cluster_word_t w;
		w.bits = bits;
		w.rows = rows;
		w.cols = cols;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Blocks until every queued word has been taken and every result is in.
	// Sampled at the falling edge, when the rising-edge bookkeeping is settled.
	task automatic wait_drained();
		while (words_taken != words_queued || tally_due.size() != 0)
			@(negedge clk);
	endtask

	// A brand-new cluster. Spans are mostly legal, sometimes anything the
	// four-bit field holds (zero and above the maximum included). Bitmaps are
	// dense, sparse, empty or full.
	function automatic cluster_word_t fresh_cluster();
		cluster_word_t w;
		w.rows = ($urandom_range(0, 19) < 3) ? SPAN_W'($urandom_range(0, 15))
			: SPAN_W'($urandom_range(1, MAX_ROWS));
		w.cols = ($urandom_range(0, 19) < 3) ? SPAN_W'($urandom_range(0, 15))
			: SPAN_W'($urandom_range(1, MAX_COLS));
		case ($urandom_range(0, 9))
			0: begin
				w.bits = '0;
			end
			1: begin
				w.bits = '1;
			end
			2, 3, 4: begin
				w.bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			end
			default: begin
				w.bits = {$urandom, $urandom};
			end
		endcase
		return w;
	endfunction

	// Mostly repeats of earlier clusters, so that hits are common: either the
	// exact word, the same topology with garbage outside the rectangle, or
	// the same topology with an oversized span that clamps to the stored one.
	function automatic cluster_word_t random_cluster();
		cluster_word_t w;
		if (shape_pool.size() != 0 && $urandom_range(0, 99) < 55) begin
			w = shape_pool[$urandom_range(0, shape_pool.size() - 1)];
			case ($urandom_range(0, 2))
				0: begin
				end
				1: begin
					w.bits = w.bits ^ ({$urandom, $urandom} & ~live_cells(w.rows, w.cols));
				end
				default: begin
					if (w.rows >= MAX_ROWS)
						w.rows = SPAN_W'($urandom_range(MAX_ROWS, 15));
					if (w.cols >= MAX_COLS)
						w.cols = SPAN_W'($urandom_range(MAX_COLS, 15));
				end
			endcase
		end else begin
			w = fresh_cluster();
			shape_pool.push_back(w);
		end
		return w;
	endfunction

	// Rising edge: note which handshakes completed, feed accepted words to the
	// shadow dictionary and check accepted results against the oldest one
	// still owed. Inputs only ever change at the falling edge, so this reads
	// settled values.
	always @(posedge clk) begin : watch_ports
		cluster_word_t seen;
		dict_result_t  want;
		in_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (in_taken) begin
			seen.bits = pattern_bits;
			seen.rows = row_span;
			seen.cols = col_span;
			tally_due.push_back(tally_cluster(seen));
			words_taken++;
		end
		if (out_taken) begin
			results_seen++;
			if (tally_due.size() == 0) begin
				report_mismatch("result word arrived with nothing owed");
			end else begin
				want = tally_due.pop_front();
				if (entry_index !== want.index)
					report_mismatch($sformatf("entry_index %0d, wanted %0d",
						entry_index, want.index));
				if (outcome !== want.kind)
					report_mismatch($sformatf("outcome %0d, wanted %0d", outcome, want.kind));
				if (entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, wanted %0d",
						entry_count, want.count));
				if (total_clusters !== want.total)
					report_mismatch($sformatf("total_clusters %0d, wanted %0d",
						total_clusters, want.total));
			end
		end
	end

	// Sender. A word stays on the port until it is taken. Before each new word
	// it idles for a drawn number of cycles, except in calm stretches where it
	// offers back to back.
	cluster_word_t next_word;
	logic          word_ready = 1'b0;
	int            send_gap = 0;
	logic          send_calm = 1'b0;

	always @(negedge clk) begin : drive_inputs
		logic drive;
		drive = in_valid;
		if (arst_n && !(in_valid && !in_taken)) begin
			drive = 1'b0;
			if (!word_ready && pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				send_gap = send_calm ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 47) == 0)
					send_calm = !send_calm;
				word_ready = 1'b1;
			end
			if (word_ready) begin
				if (send_gap == 0) begin
					drive = 1'b1;
					pattern_bits <= next_word.bits;
					row_span <= next_word.rows;
					col_span <= next_word.cols;
					word_ready = 1'b0;
				end else begin
					send_gap--;
				end
			end
		end
		in_valid <= drive;
	end

	// Receiver. After each result it stalls for a drawn number of cycles, with
	// calm stretches of none. Once, early in the random part, it holds off for
	// a long stretch so the block fills its output register, stops taking
	// words and stalls the sender, which keeps offering.
	int   stall_left = 0;
	int   hold_left = 0;
	logic recv_calm = 1'b0;

	always @(negedge clk) begin : drive_stall
		logic hold;
		if (out_taken) begin
			stall_left = recv_calm ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 47) == 0)
				recv_calm = !recv_calm;
			if (results_seen == HOLD_AT_RESULT)
				hold_left = HOLD_CYCLES;
		end
		hold = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			hold = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			hold = 1'b1;
		end
		out_stall <= hold;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		cluster_word_t w;
		cluster_word_t newest_fill;
		int            room;
		int            fill_serial;
		fill_serial = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. The first word opens slot zero with an empty 1x1
		// cluster; later words lean on it.
		queue_cluster('0, 4'd1, 4'd1);
		queue_cluster('0, 4'd1, 4'd1);                         // hit, count two
		queue_cluster('1, 4'd8, 4'd8);                         // full rectangle
		queue_cluster('1, 4'd1, 4'd1);                         // masks down to bit zero
		queue_cluster(64'hFFFF_FFFF_FFFF_FFFE, 4'd1, 4'd1);    // masks to empty, hits slot 0
		queue_cluster('1, 4'd12, 4'd8);                        // rows clamp to eight
		queue_cluster('1, 4'd15, 4'd15);                       // both spans clamp
		queue_cluster(64'h1234_5678_9ABC_DEF0, 4'd0, 4'd5);    // zero rows: bitmap cleared
		queue_cluster(64'hFEDC_BA98_7654_3210, 4'd0, 4'd5);    // same topology after clearing
		queue_cluster(64'h8000_0000_0000_0001, 4'd3, 4'd0);    // zero columns
		queue_cluster('1, 4'd0, 4'd0);
		queue_cluster(64'hFF, 4'd8, 4'd1);                     // same bits, spans swapped:
		queue_cluster(64'hFF, 4'd1, 4'd8);                     // two distinct entries
		queue_cluster(64'h2A, 4'd2, 4'd3);
		queue_cluster(64'h2A, 4'd3, 4'd2);
		queue_cluster(64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 4'd8);
		queue_cluster(64'h5555_5555_5555_5555, 4'd8, 4'd8);
		queue_cluster(64'hDEAD_BEEF_0000_FFFF, 4'd4, 4'd4);    // garbage above the rectangle
		queue_cluster(64'h0000_0000_0000_FFFF, 4'd4, 4'd4);    // clean copy, must hit
		queue_cluster(64'h0000_0000_0000_0001, 4'd9, 4'd1);
		queue_cluster(64'h0000_0000_0000_0001, 4'd8, 4'd1);    // hits the clamped entry
		queue_cluster(64'h8000_0000_0000_0000, 4'd8, 4'd8);    // top bitmap bit alone

		// Random part in two halves, with a full pause between them so the
		// block is seen starting again from idle.
		repeat (RANDOM_WORDS / 2) begin
			w = random_cluster();
			queue_cluster(w.bits, w.rows, w.cols);
		end
		wait_drained();
		repeat (RANDOM_WORDS - RANDOM_WORDS / 2) begin
			w = random_cluster();
			queue_cluster(w.bits, w.rows, w.cols);
		end
		wait_drained();

		// Fill the dictionary to the last slot with distinct 8x8 topologies.
		// The serial number in the low bits keeps them apart; a rare clash with
		// an earlier entry just leaves room, so the loop tops up again.
		while (dict_used < TABLE_DEPTH) begin
			room = TABLE_DEPTH - dict_used;
			repeat (room) begin
				w.bits = {$urandom, $urandom};
				w.bits[11:0] = fill_serial[11:0];
				w.rows = SPAN_W'($urandom_range(MAX_ROWS, 15));
				w.cols = SPAN_W'($urandom_range(MAX_COLS, 15));
				fill_serial++;
				newest_fill = w;
				queue_cluster(w.bits, w.rows, w.cols);
			end
			wait_drained();
		end

		// Table full: unknown topologies are dropped, known ones still hit,
		// at the first slot and at the last one.
		queue_cluster(~newest_fill.bits, 4'd8, 4'd8);
		queue_cluster('0, 4'd1, 4'd1);
		queue_cluster(newest_fill.bits, newest_fill.rows, newest_fill.cols);
		queue_cluster(64'hFFFF_FFFF_FFFF_FFF1, 4'd1, 4'd1);
		repeat (6) begin
			w = random_cluster();
			queue_cluster(w.bits, w.rows, w.cols);
		end
		w = fresh_cluster();
		queue_cluster(w.bits, w.rows, w.cols);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
